// ----- design/dss_pkg.sv -----
`default_nettype none

package dss_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_BYTES  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEPARATOR_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LIMIT    = 2'd2;

  // Number of entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Configuration as seen by the front part.
  typedef struct packed {
    logic [63:0] separator_bytes;
    logic [3:0]  separator_length;
    logic [7:0]  segment_limit;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [15:0] segment_offset;
    logic [15:0] segment_length;
    logic [7:0]  segment_number;
    logic        no_separator;
    logic        list_end;
  } result_t;

  // One queue entry: the results caused by one input byte.
  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } entry_t;

  // Write request from the front part into the queue.
  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

`default_nettype wire

// ----- design/dss_front.sv -----
`default_nettype none

module dss_front
  import dss_pkg::*;
#(
  parameter int MAX_SEPARATOR_BYTES = 8,
  parameter int MAX_RECORD_BYTES = 65536
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       record_end,
  input  wire logic       queue_full,
  output push_t           queue_write
);

  localparam int WIN_W = 8 * MAX_SEPARATOR_BYTES;
  localparam int POS_W = $clog2(MAX_RECORD_BYTES + 1);

  logic [WIN_W-1:0] window;
  logic [WIN_W-1:0] window_next;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] position_next;
  logic [POS_W-1:0] seg_start;
  logic [POS_W-1:0] seg_start_next;
  logic [7:0]       found;
  logic [7:0]       found_next;
  logic             limit_reached;
  logic             limit_reached_next;

  logic                           accept;
  logic                           active;
  logic [3:0]                     eff_len;
  logic [7:0]                     eff_limit;
  logic [WIN_W-1:0]               window_shift;
  logic [POS_W-1:0]               pos_inc;
  logic [POS_W-1:0]               sep_at;
  logic [MAX_SEPARATOR_BYTES-1:0] byte_ok;
  logic                           far_enough;
  logic                           hit;
  logic                           limit_hit;
  logic [7:0]                     found_inc;
  result_t                        hit_res;
  result_t                        limit_res;
  result_t                        end_res;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Effective configuration: length clamped to 1..max, limit at least 1.
  always_comb begin
    eff_len = cfg.separator_length;
    if (eff_len == 4'd0) begin
      eff_len = 4'd1;
    end else if (eff_len > 4'(MAX_SEPARATOR_BYTES)) begin
      eff_len = 4'(MAX_SEPARATOR_BYTES);
    end
    eff_limit = (cfg.segment_limit == 8'd0) ? 8'd1 : cfg.segment_limit;
  end

  // Separator match on the window including the incoming byte.
  always_comb begin
    active       = !limit_reached && (position < POS_W'(MAX_RECORD_BYTES));
    window_shift = (window << 8) | WIN_W'(data_byte);
    pos_inc      = position + 1'b1;
    sep_at       = pos_inc - POS_W'(eff_len);
    for (int i = 0; i < MAX_SEPARATOR_BYTES; i++) begin
      byte_ok[i] = (window_shift[8*i +: 8] == cfg.separator_bytes[8*i +: 8])
                   || (4'(i) >= eff_len);
    end
    // The separator must start at or after the current segment start.
    far_enough = {1'b0, pos_inc} >= ({1'b0, seg_start} + (POS_W + 1)'(eff_len));
    hit        = accept && active && far_enough && (&byte_ok);
    found_inc  = found + 8'd1;
    limit_hit  = hit && (found_inc >= eff_limit);
  end

  // Record state update; the last byte of a record clears everything.
  always_comb begin
    window_next        = window;
    position_next      = position;
    seg_start_next     = seg_start;
    found_next         = found;
    limit_reached_next = limit_reached;
    if (accept && active) begin
      window_next   = window_shift;
      position_next = pos_inc;
    end
    if (hit) begin
      seg_start_next = pos_inc;
      found_next     = found_inc;
      if (limit_hit) begin
        limit_reached_next = 1'b1;
      end
    end

    // Result for the record's last byte, from the state after this byte.
    if (found_next == 8'd0) begin
      end_res = '{segment_offset: 16'd0, segment_length: 16'd0,
                  segment_number: 8'd0, no_separator: 1'b1, list_end: 1'b1};
    end else begin
      end_res = '{segment_offset: 16'(seg_start_next),
                  segment_length: 16'(position_next - seg_start_next),
                  segment_number: found_next, no_separator: 1'b0, list_end: 1'b1};
    end

    if (accept && record_end) begin
      window_next        = '0;
      position_next      = '0;
      seg_start_next     = '0;
      found_next         = '0;
      limit_reached_next = 1'b0;
    end
  end

  // Queue entry for this byte.
  always_comb begin
    hit_res = '{segment_offset: 16'(seg_start), segment_length: 16'(sep_at - seg_start),
                segment_number: found, no_separator: 1'b0, list_end: 1'b0};
    limit_res = '{segment_offset: 16'(pos_inc), segment_length: 16'd0,
                  segment_number: found_inc, no_separator: 1'b0, list_end: 1'b1};
    queue_write.push = 1'b0;
    queue_write.entry.first  = end_res;
    queue_write.entry.second = end_res;
    queue_write.entry.two    = 1'b0;
    if (hit) begin
      queue_write.push        = 1'b1;
      queue_write.entry.first = hit_res;
      if (limit_hit) begin
        queue_write.entry.second = limit_res;
        queue_write.entry.two    = 1'b1;
      end else if (record_end) begin
        queue_write.entry.two = 1'b1;
      end
    end else if (accept && record_end && !limit_reached) begin
      queue_write.push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= '0;
      position      <= '0;
      seg_start     <= '0;
      found         <= '0;
      limit_reached <= 1'b0;
    end else begin
      window        <= window_next;
      position      <= position_next;
      seg_start     <= seg_start_next;
      found         <= found_next;
      limit_reached <= limit_reached_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/dss_queue.sv -----
`default_nettype none

module dss_queue
  import dss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire push_t  queue_write,
  output logic        full,
  input  wire logic   pop,
  output logic        empty,
  output entry_t      head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t           storage [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = storage[rd_ptr];

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (queue_write.push) begin
      storage[wr_ptr] <= queue_write.entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (queue_write.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (queue_write.push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !queue_write.push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/dss_back.sv -----
`default_nettype none

module dss_back
  import dss_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   empty,
  input  wire entry_t head,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output result_t     out_result
);

  logic    pending;
  result_t pending_result;
  logic    load;

  // The output register may take a new result when empty or being drained.
  assign load = !out_valid || out_ready;
  assign pop  = load && !pending && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else if (!empty) begin
        out_valid <= 1'b1;
        pending   <= head.two;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: the second result of an entry waits in its own register.
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        out_result <= pending_result;
      end else if (!empty) begin
        out_result     <= head.first;
        pending_result <= head.second;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/delimiter_segment_splitter.sv -----
// Splits records into segments at a configured separator of 1 to 8 bytes.
// Input channel (in_valid/in_ready): one record byte per transfer, with
// record_end set on the last byte of a record. Output channel
// (out_valid/out_ready): one segment description per transfer; list_end
// marks the last result of a record, no_separator a record without any match.
// Configuration: cfg_write_enable writes cfg_write_data into the register
// selected by cfg_index at the clock edge; write only while the block is idle.
// Throughput: one byte per cycle while the queue is not full. A byte that
// yields two results occupies the output register twice; the four-entry
// result queue absorbs that. The queue is written at the edge that transfers
// the byte, and the output register loads from the queue head; the second
// result of a byte waits in its own register and follows the first.
// When the receiver stalls, results collect in the queue; in_ready drops
// only while the queue is full. Bytes that cause no result never wait on
// the output side beyond that.
// Reset (synchronous, rst high) empties the queue and output register,
// clears the record state and returns the registers to separator 0x00,
// length 1 and limit 255.
`default_nettype none

module delimiter_segment_splitter
  import dss_pkg::*;
#(
  parameter int MAX_SEPARATOR_BYTES = 8,
  parameter int MAX_RECORD_BYTES = 65536
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_enable,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [63:0]            cfg_write_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   record_end,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [15:0]                 segment_offset,
  output logic [15:0]                 segment_length,
  output logic [7:0]                  segment_number,
  output logic                        no_separator,
  output logic                        list_end
);

  cfg_t    cfg;
  push_t   queue_write;
  logic    queue_full;
  logic    queue_empty;
  logic    queue_pop;
  entry_t  queue_head;
  result_t out_result;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.separator_bytes  <= 64'd0;
      cfg.separator_length <= 4'd1;
      cfg.segment_limit    <= 8'd255;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_SEPARATOR_BYTES:  cfg.separator_bytes  <= cfg_write_data;
        REG_SEPARATOR_LENGTH: cfg.separator_length <= cfg_write_data[3:0];
        REG_SEGMENT_LIMIT:    cfg.segment_limit    <= cfg_write_data[7:0];
        default: ;
      endcase
    end
  end

  dss_front #(
    .MAX_SEPARATOR_BYTES(MAX_SEPARATOR_BYTES),
    .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .record_end  (record_end),
    .queue_full  (queue_full),
    .queue_write (queue_write)
  );

  dss_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .queue_write (queue_write),
    .full        (queue_full),
    .pop         (queue_pop),
    .empty       (queue_empty),
    .head        (queue_head)
  );

  dss_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (queue_empty),
    .head       (queue_head),
    .pop        (queue_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

  assign segment_offset = out_result.segment_offset;
  assign segment_length = out_result.segment_length;
  assign segment_number = out_result.segment_number;
  assign no_separator   = out_result.no_separator;
  assign list_end       = out_result.list_end;

  // The front part never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    queue_write.push |-> !queue_full)
    else $error("result queue written while full");

  // A record without a separator ends with an empty, final result.
  a_no_sep_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && no_separator) |->
      (list_end && segment_offset == 16'd0 && segment_length == 16'd0))
    else $error("no-separator result is malformed");

  // Reset leaves the output register and the queue empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && queue_empty))
    else $error("output or queue not empty after reset");

endmodule

`default_nettype wire
